// ===== hdl/frame_duplicate_suppressor_assert.svh =====
// assertion macros shared by the checker
`ifndef FRAME_DUPLICATE_SUPPRESSOR_ASSERT_SVH
`define FRAME_DUPLICATE_SUPPRESSOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define FDS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame duplicate suppressor check failed");

// antecedent implies consequent in the next cycle
`define FDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame duplicate suppressor check failed");

`endif

// ===== hdl/fds_pkg.sv =====
`timescale 1ns / 1ps

package fds_pkg;

    localparam int unsigned HASH_SHL     = 5;
    localparam int unsigned HASH_SHR     = 2;
    localparam logic [31:0] WINDOW_RESET = 32'd60000;

    localparam int unsigned S_TDATA_W = 88;
    localparam int unsigned M_TDATA_W = 48;
    localparam int unsigned M_TUSER_W = 2;

    typedef struct packed {
        logic [15:0] hash;
        logic [47:0] call;
        logic [31:0] stamp;
    } entry_t;

    typedef struct packed {
        logic   ok;
        entry_t ent;
    } frame_ctx_t;

    function automatic logic [15:0] fold_byte(input logic [15:0] h, input logic [7:0] b);
        logic [15:0] r;
        r = (h << HASH_SHL) ^ (h >> HASH_SHR) ^ {8'h00, b};
        return r;
    endfunction

endpackage

// ===== hdl/fds_hash.sv =====
`timescale 1ns / 1ps

module fds_hash
    import fds_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       data_byte,
    input  logic             last,
    input  logic             frame_ok,
    input  logic [47:0]      source_call,
    input  logic [31:0]      arrival_ms,
    input  logic             advance,
    output logic             ctx_valid,
    output frame_ctx_t       ctx
);

    logic [15:0] hash_reg;
    logic [15:0] hash_next;
    logic [15:0] hash_fold;
    logic        ctx_valid_reg;
    logic        ctx_valid_next;
    frame_ctx_t  ctx_reg;

    assign hash_fold = fold_byte(hash_reg, data_byte);

    always_comb
    begin
        hash_next      = hash_reg;
        ctx_valid_next = ctx_valid_reg;
        if (advance)
        begin
            ctx_valid_next = 1'b0;
        end
        if (take)
        begin
            if (last)
            begin
                hash_next      = 16'h0000;
                ctx_valid_next = 1'b1;
            end
            else
            begin
                hash_next = hash_fold;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= 16'h0000;
            ctx_valid_reg <= 1'b0;
        end
        else
        begin
            hash_reg      <= hash_next;
            ctx_valid_reg <= ctx_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && last)
        begin
            ctx_reg.ok        <= frame_ok;
            ctx_reg.ent.hash  <= hash_fold;
            ctx_reg.ent.call  <= source_call;
            ctx_reg.ent.stamp <= arrival_ms;
        end
    end

    assign ctx_valid = ctx_valid_reg;
    assign ctx       = ctx_reg;

endmodule

// ===== hdl/fds_cell.sv =====
`timescale 1ns / 1ps

module fds_cell
    import fds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        shift_en,
    input  logic        prev_valid,
    input  entry_t      prev_entry,
    input  entry_t      probe,
    input  logic [31:0] window_ms,
    output logic        valid,
    output entry_t      entry,
    output logic        match
);

    logic        valid_reg;
    entry_t      entry_reg;
    logic [31:0] age;

    assign age   = probe.stamp - entry_reg.stamp;
    assign match = valid_reg && (entry_reg.hash == probe.hash)
                   && (entry_reg.call == probe.call) && (age < window_ms);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= prev_entry;
        end
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

// ===== hdl/frame_duplicate_suppressor.sv =====
`timescale 1ns / 1ps
// frame context registered on the final byte, then the result word once output is free
// throughput: one byte per cycle while the output is not back-pressured, frames back to
//   back, limited by the single compare and insert step across the row of entry cells
// reset: asynchronous, clears entry valid bits, hash, counters and handshake state;
//   window_ms returns to 60000, entry payload is not cleared and needs no clearing pass
module frame_duplicate_suppressor
    import fds_pkg::*;
#(
    parameter int TABLE_ENTRIES = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // data_byte, source_call, arrival_ms
    input  logic                 s_tlast,   // end_of_frame
    input  logic                 s_tuser,   // frame_ok
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // frame_hash, accepted_total, duplicate_total
    output logic [M_TUSER_W-1:0] m_tuser    // accepted, duplicate
);

    logic [31:0]              window_reg;
    logic                     take;
    logic                     out_free;
    logic                     advance;
    logic                     ctx_valid;
    frame_ctx_t               ctx;
    logic [TABLE_ENTRIES-1:0] match_vec;
    logic [TABLE_ENTRIES:0]   chain_valid;
    entry_t                   chain_entry [TABLE_ENTRIES+1];
    logic                     is_dup;
    logic                     insert;
    logic                     count_dup;
    logic [15:0]              acc_cnt_reg;
    logic [15:0]              acc_cnt_next;
    logic [15:0]              dup_cnt_reg;
    logic [15:0]              dup_cnt_next;
    logic                     m_tvalid_reg;
    logic                     m_tvalid_next;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic [M_TUSER_W-1:0]     m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_wr_en)
        begin
            window_reg <= cfg_wr_data;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign advance  = ctx_valid && out_free;
    assign s_tready = !ctx_valid || out_free;
    assign take     = s_tvalid && s_tready;

    fds_hash u_hash (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .data_byte   (s_tdata[7:0]),
        .last        (s_tlast),
        .frame_ok    (s_tuser),
        .source_call (s_tdata[55:8]),
        .arrival_ms  (s_tdata[87:56]),
        .advance     (advance),
        .ctx_valid   (ctx_valid),
        .ctx         (ctx)
    );

    // newest entry enters at cell 0, oldest falls off the end
    assign chain_valid[0] = 1'b1;
    assign chain_entry[0] = ctx.ent;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            fds_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift_en   (insert),
                .prev_valid (chain_valid[gi]),
                .prev_entry (chain_entry[gi]),
                .probe      (ctx.ent),
                .window_ms  (window_reg),
                .valid      (chain_valid[gi+1]),
                .entry      (chain_entry[gi+1]),
                .match      (match_vec[gi])
            );
        end
    endgenerate

    assign is_dup    = |match_vec;
    assign insert    = advance && ctx.ok && !is_dup;
    assign count_dup = advance && ctx.ok && is_dup;

    assign acc_cnt_next = insert ? acc_cnt_reg + 16'd1 : acc_cnt_reg;
    assign dup_cnt_next = count_dup ? dup_cnt_reg + 16'd1 : dup_cnt_reg;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (advance)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_cnt_reg  <= 16'h0000;
            dup_cnt_reg  <= 16'h0000;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            acc_cnt_reg  <= acc_cnt_next;
            dup_cnt_reg  <= dup_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_tdata_reg <= {dup_cnt_next, acc_cnt_next, ctx.ent.hash};
            m_tuser_reg <= {count_dup, insert};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== hdl/fds_checker.sv =====
`timescale 1ns / 1ps
`include "frame_duplicate_suppressor_assert.svh"

module fds_checker
    import fds_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tready,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser
);

    // a word is never both stored and dropped
    `FDS_ASSERT_SAME(a_flags_exclusive, clk, rst_n, m_tvalid, !(m_tuser[0] && m_tuser[1]))

    // input only stalls under output back pressure
    `FDS_ASSERT_SAME(a_stall_only_backpressure, clk, rst_n, !s_tready, m_tvalid && !m_tready)

    // stalled result word holds
    `FDS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // output valid only drops after a handshake
    `FDS_ASSERT_SAME(a_out_drop, clk, rst_n, $fell(m_tvalid), $past(m_tready))

endmodule

bind frame_duplicate_suppressor fds_checker u_fds_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
